@@ hw/rtl/pres80_pkg.sv @@
// Shared types, constants and round functions for the PRESENT-80 encryptor.
// No dependencies; every other file refers to it by scoped names.
package pres80_pkg;

   localparam int BLOCK_W = 64;
   localparam int KEY_W   = 80;
   localparam int RC_W    = 5;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [RC_W-1:0]    rc_type;
   typedef logic [3:0]         nibble_type;

   // Configuration register indexes
   typedef logic [0:0] csr_idx_type;
   localparam csr_idx_type CSR_KEY_UPPER = 1'b0;
   localparam csr_idx_type CSR_KEY_LOWER = 1'b1;

   // Payload carried from one round stage to the next
   typedef struct packed {
      block_type state;
      key_type   key;
   } stage_type;

   localparam nibble_type SBOX [16] = '{
      4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
      4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   function automatic block_type sbox_layer(block_type s);
      block_type r;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = SBOX[s[4*n +: 4]];
      end
      return r;
   endfunction

   // Bit i moves to 16*i mod 63; bit 63 stays put
   function automatic block_type perm_layer(block_type s);
      block_type r;
      r = '0;
      for (int b = 0; b < 63; b++) begin
         r[(16 * b) % 63] = s[b];
      end
      r[63] = s[63];
      return r;
   endfunction

   // Key schedule step: rotate left 61, S-box top nibble, round counter into 19..15
   function automatic key_type key_update(key_type k, rc_type rc);
      key_type r;
      r = {k[18:0], k[79:19]};
      r[79:76] = SBOX[r[79:76]];
      r[19:15] = r[19:15] ^ rc;
      return r;
   endfunction

endpackage

@@ hw/rtl/pres80_intf.sv @@
// Valid/ready channel interfaces for plaintext, ciphertext and key writes.
// Depends on pres80_pkg for payload types.
interface pres80_req_if;
   logic                   valid;
   logic                   ready;
   pres80_pkg::block_type  plain_block;
   modport source (output valid, output plain_block, input ready);
   modport sink   (input valid, input plain_block, output ready);
endinterface

interface pres80_rsp_if;
   logic                   valid;
   logic                   ready;
   pres80_pkg::block_type  cipher_block;
   modport source (output valid, output cipher_block, input ready);
   modport sink   (input valid, input cipher_block, output ready);
endinterface

interface pres80_csr_if;
   logic                     valid;
   logic                     ready;
   pres80_pkg::csr_idx_type  index;
   pres80_pkg::block_type    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/present80_block_encrypt.sv @@
// PRESENT-80 encryptor, one round per register stage plus an output register.
// NUM_ROUNDS + 1 register stages, the round stages and then the output register; a block
// taken by a req transaction passes through them in order and is held under rsp stall.
// Throughput: one block per cycle unless rsp stalls; one S-box/permute layer per stage.
// Reset (synchronous) empties all stages and clears the key to zero.
// Depends on pres80_pkg, the channel interfaces, pres80_csr and pres80_round.
module present80_block_encrypt #(
   parameter int NUM_ROUNDS = 31
) (
   input  logic          clock,
   input  logic          reset,
   pres80_req_if.sink    req_if,
   pres80_rsp_if.source  rsp_if,
   pres80_csr_if.sink    csr_if
);

   pres80_pkg::key_type   key;
   logic                  stage_valid [NUM_ROUNDS+1];
   logic                  stage_ready [NUM_ROUNDS+1];
   pres80_pkg::stage_type stage_data  [NUM_ROUNDS+1];

   logic                  rsp_valid_ff, rsp_valid_in;
   pres80_pkg::block_type cipher_ff, cipher_in;
   logic                  rsp_load;

   pres80_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .key    (key)
   );

   // Pipeline entry
   assign stage_valid[0] = req_if.valid;
   assign stage_data[0]  = {req_if.plain_block, key};
   assign req_if.ready   = stage_ready[0];

   // Round stages
   for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
      pres80_round u_round (
         .clock     (clock),
         .reset     (reset),
         .rc        (pres80_pkg::rc_type'(g + 1)),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   // Output register with final key add
   assign stage_ready[NUM_ROUNDS] = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load  = stage_valid[NUM_ROUNDS] && stage_ready[NUM_ROUNDS];
   assign cipher_in = stage_data[NUM_ROUNDS].state ^ stage_data[NUM_ROUNDS].key[79:16];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         cipher_ff <= cipher_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.cipher_block = cipher_ff;

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_if.valid)
      else $error("rsp valid right after reset");

   // Input backpressure only when the first stage holds a block
   a_entry_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> stage_valid[1])
      else $error("req stalled with empty first stage");

   // A stalled output keeps the last round stage occupied
   a_tail_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready && stage_valid[NUM_ROUNDS]) |=> stage_valid[NUM_ROUNDS])
      else $error("last stage dropped a block under stall");

endmodule

@@ hw/rtl/pres80_csr.sv @@
// Key register bank: holds the 80-bit key written through the csr channel.
// Depends on pres80_pkg and pres80_csr_if.
module pres80_csr (
   input  logic                 clock,
   input  logic                 reset,
   pres80_csr_if.sink           csr_if,
   output pres80_pkg::key_type  key
);

   pres80_pkg::key_type key_ff, key_in;

   assign csr_if.ready = 1'b1;

   // Register decode
   always_comb begin
      key_in = key_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            pres80_pkg::CSR_KEY_UPPER: key_in[79:16] = csr_if.data;
            pres80_pkg::CSR_KEY_LOWER: key_in[15:0]  = csr_if.data[15:0];
            default:                   key_in        = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

@@ hw/rtl/pres80_round.sv @@
// One pipelined cipher round: key add, S-box layer, bit permutation, key update.
// Depends on pres80_pkg.
module pres80_round (
   input  logic                   clock,
   input  logic                   reset,
   input  pres80_pkg::rc_type     rc,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pres80_pkg::stage_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pres80_pkg::stage_type  out_data
);

   logic                  valid_ff, valid_in;
   pres80_pkg::stage_type data_ff, data_in;
   logic                  load;

   // Stage frees up when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Round datapath
   always_comb begin
      data_in.state = pres80_pkg::perm_layer(
                         pres80_pkg::sbox_layer(in_data.state ^ in_data.key[79:16]));
      data_in.key   = pres80_pkg::key_update(in_data.key, rc);
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
